// ----- rtl/crg_pkg.sv -----
package crg_pkg;

    // Field and register widths.
    localparam int IDX_W      = 8;
    localparam int ENTRY_W    = 9;
    localparam int COUNT_W    = 3;
    localparam int STOP_W     = 49;
    localparam int POS_W      = 17;
    localparam int COLOR_W    = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;

    // Table limits.
    localparam int MAX_ENTRIES = 256;
    localparam int MAX_STOPS   = 4;
    localparam int STOP_REGS   = 4;
    localparam int STOP_LIM    = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;
    localparam int LAST_W      = (STOP_REGS > 1) ? $clog2(STOP_REGS) : 1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

    // Blend and divider datapath.
    localparam int SPAN_W      = 9;
    localparam int NUM_W       = 16;
    localparam int REM_W       = 17;
    localparam int DIV_STAGES  = 8;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef enum logic [2:0] {
        REG_ENTRY_COUNT = 3'd0,
        REG_STOP_COUNT  = 3'd1,
        REG_STOP_ZERO   = 3'd2,
        REG_STOP_ONE    = 3'd3,
        REG_STOP_TWO    = 3'd4,
        REG_STOP_THREE  = 3'd5
    } t_reg_idx;

    // Configuration as seen by the front.
    typedef struct packed {
        logic [ENTRY_W-1:0]                entry_count;
        logic [COUNT_W-1:0]                stop_count;
        logic [STOP_REGS-1:0][STOP_W-1:0]  stops;
    } t_cfg;

    // One classified entry: the segment it falls in and the two end colors.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SPAN_W-1:0]  span;
        logic [IDX_W-1:0]   offset;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
    } t_job;

    // Stop position, saturated at one.
    function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] stop);
        logic [POS_W-1:0] p;
        p = stop[STOP_W-1:COLOR_W];
        return (p > POS_ONE) ? POS_ONE : p;
    endfunction

    function automatic logic [COLOR_W-1:0] stop_color(input logic [STOP_W-1:0] stop);
        return stop[COLOR_W-1:0];
    endfunction

endpackage

// ----- rtl/crg_front.sv -----
module crg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crg_pkg::t_cfg     i_cfg,
    input  logic              i_push,
    input  logic [7:0]        i_entry_index,
    output logic              o_full,
    input  logic              i_queue_full,
    output logic              o_job_valid,
    output crg_pkg::t_job     o_job
);
    import crg_pkg::*;

    localparam int PROD_W = POS_W + ENTRY_W;

    logic                    r_a_valid;
    logic [IDX_W-1:0]        r_a_idx;
    logic                    r_b_valid;
    logic [IDX_W-1:0]        r_b_idx;
    logic [ENTRY_W-1:0]      r_b_len;
    logic [LAST_W-1:0]       r_b_last;
    logic [ENTRY_W-1:0]      r_b_start [STOP_REGS];

    logic                    advance;
    logic [ENTRY_W-1:0]      len;
    logic [LAST_W-1:0]       last;
    logic [ENTRY_W-1:0]      n_start [STOP_REGS];

    // The front moves as one unless its last stage waits on a full queue.
    assign advance     = !(r_b_valid && i_queue_full);
    assign o_full      = !advance;
    assign o_job_valid = r_b_valid && advance;

    // Table length and last stop index from the registers.
    always_comb begin
        logic [COUNT_W-1:0] cnt;
        len = (i_cfg.entry_count > ENTRY_W'(MAX_ENTRIES)) ?
              ENTRY_W'(MAX_ENTRIES) : i_cfg.entry_count;
        cnt = i_cfg.stop_count;
        if (cnt == '0) begin
            cnt = COUNT_W'(1);
        end
        if (cnt > COUNT_W'(STOP_LIM)) begin
            cnt = COUNT_W'(STOP_LIM);
        end
        last = LAST_W'(cnt - COUNT_W'(1));
    end

    // Start entry of each stop: floor(position * length / 65536).
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < STOP_REGS; i++) begin
            prod       = PROD_W'(stop_pos(i_cfg.stops[i])) * PROD_W'(len);
            n_start[i] = prod[16 +: ENTRY_W];
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_push;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_idx  <= i_entry_index;
            r_b_idx  <= r_a_idx;
            r_b_len  <= len;
            r_b_last <= last;
            for (int i = 0; i < STOP_REGS; i++) begin
                r_b_start[i] <= n_start[i];
            end
        end
    end

    // Pick the covering range; later ranges override earlier ones.
    always_comb begin
        logic [ENTRY_W-1:0] idx9;
        logic [ENTRY_W-1:0] lo;
        logic [ENTRY_W-1:0] hi;
        logic               covered;
        idx9    = ENTRY_W'(r_b_idx);
        lo      = '0;
        hi      = ENTRY_W'(1);
        covered = 1'b0;
        o_job.color_a = '0;
        o_job.color_b = '0;
        if (idx9 < r_b_len) begin
            if (stop_pos(i_cfg.stops[0]) != '0 && idx9 < r_b_start[0]) begin
                covered       = 1'b1;
                lo            = '0;
                hi            = r_b_start[0];
                o_job.color_a = stop_color(i_cfg.stops[0]);
                o_job.color_b = stop_color(i_cfg.stops[0]);
            end
            for (int i = 0; i < STOP_REGS - 1; i++) begin
                if (LAST_W'(i) < r_b_last && idx9 >= r_b_start[i] &&
                    idx9 < r_b_start[i+1]) begin
                    covered       = 1'b1;
                    lo            = r_b_start[i];
                    hi            = r_b_start[i+1];
                    o_job.color_a = stop_color(i_cfg.stops[i]);
                    o_job.color_b = stop_color(i_cfg.stops[i+1]);
                end
            end
            if (stop_pos(i_cfg.stops[r_b_last]) < POS_ONE &&
                idx9 >= r_b_start[r_b_last]) begin
                covered       = 1'b1;
                lo            = r_b_start[r_b_last];
                hi            = r_b_len;
                o_job.color_a = stop_color(i_cfg.stops[r_b_last]);
                o_job.color_b = stop_color(i_cfg.stops[r_b_last]);
            end
        end
        if (!covered) begin
            lo = '0;
            hi = ENTRY_W'(1);
        end
        o_job.idx    = r_b_idx;
        o_job.span   = SPAN_W'(hi - lo);
        o_job.offset = IDX_W'(idx9 - lo);
    end

endmodule

// ----- rtl/crg_queue.sv -----
module crg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  crg_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output crg_pkg::t_job  o_data
);
    import crg_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/crg_back.sv -----
module crg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  crg_pkg::t_job  i_job,
    output logic           o_job_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_index_echo,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_alpha
);
    import crg_pkg::*;

    localparam int NSTG = DIV_STAGES + 1;

    logic                r_valid [NSTG];
    logic [IDX_W-1:0]    r_idx   [NSTG];
    logic [SPAN_W-1:0]   r_span  [NSTG];
    logic [NUM_W-1:0]    r_rem   [NSTG][NUM_CH];
    logic [CH_W-1:0]     r_quo   [NSTG][NUM_CH];

    logic                advance;
    logic [NUM_W-1:0]    n_num   [NUM_CH];
    logic [NUM_W-1:0]    n_rem   [DIV_STAGES][NUM_CH];
    logic [CH_W-1:0]     n_quo   [DIV_STAGES][NUM_CH];

    // The final stage doubles as the output register.
    assign advance   = !r_valid[NSTG-1] || i_pop;
    assign o_job_pop = advance && !i_job_empty;
    assign o_empty   = !r_valid[NSTG-1];

    // Blend numerator per channel: a*(span-offset) + b*offset.
    always_comb begin
        logic [CH_W-1:0]  a;
        logic [CH_W-1:0]  b;
        logic [SPAN_W-1:0] w;
        logic [REM_W-1:0]  sum;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            a   = i_job.color_a[ch*CH_W +: CH_W];
            b   = i_job.color_b[ch*CH_W +: CH_W];
            w   = i_job.span - SPAN_W'(i_job.offset);
            sum = REM_W'(a) * REM_W'(w) + REM_W'(b) * REM_W'(i_job.offset);
            n_num[ch] = NUM_W'(sum);
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        logic [REM_W-1:0] trial;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                trial        = REM_W'(r_span[s]) << (DIV_STAGES - 1 - s);
                n_rem[s][ch] = r_rem[s][ch];
                n_quo[s][ch] = r_quo[s][ch];
                if (REM_W'(r_rem[s][ch]) >= trial) begin
                    n_rem[s][ch] = NUM_W'(REM_W'(r_rem[s][ch]) - trial);
                    n_quo[s][ch][DIV_STAGES - 1 - s] = 1'b1;
                end
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (advance) begin
            r_valid[0] <= !i_job_empty;
            for (int s = 1; s < NSTG; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_idx[0]  <= i_job.idx;
            r_span[0] <= i_job.span;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_rem[0][ch] <= n_num[ch];
                r_quo[0][ch] <= '0;
            end
            for (int s = 1; s < NSTG; s++) begin
                r_idx[s]  <= r_idx[s-1];
                r_span[s] <= r_span[s-1];
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    r_rem[s][ch] <= n_rem[s-1][ch];
                    r_quo[s][ch] <= n_quo[s-1][ch];
                end
            end
        end
    end

    // Channel 3 is red in the top byte, channel 0 alpha in the bottom.
    assign o_index_echo = r_idx[NSTG-1];
    assign o_red        = r_quo[NSTG-1][3];
    assign o_green      = r_quo[NSTG-1][2];
    assign o_blue       = r_quo[NSTG-1][1];
    assign o_alpha      = r_quo[NSTG-1][0];

endmodule

// ----- rtl/color_gradient_ramp.sv -----
// Color gradient ramp: push an 8-bit entry index and pop the RGBA byte color
// of that table entry, with the index echoed beside it. The table length and
// up to four color stops (17-bit position in 1/65536 units above a 32-bit RGBA
// color) are set through the 64-bit APB port, one register every eight bytes,
// and must only be changed while no lookup is in flight. Lookups are
// independent, so one entry is accepted and one delivered every clock while
// results are popped as they arrive; a result passes through two front stages
// that compute the stop start entries and pick the segment, the four-entry
// queue, one blend multiply stage and an eight-stage restoring divider that
// resolves one quotient bit per stage.
// The result register holds its beat until popped while the queue keeps taking
// new indexes.
module color_gradient_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Lookup input.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_entry_index,
    // Lookup result.
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_index_echo,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import crg_pkg::*;

    logic [ENTRY_W-1:0]  r_entry_count;
    logic [COUNT_W-1:0]  r_stop_count;
    logic [STOP_W-1:0]   r_stop [STOP_REGS];

    t_cfg      cfg;
    t_job      front_job;
    t_job      back_job;
    logic      front_valid;
    logic      queue_full;
    logic      queue_empty;
    logic      queue_pop;
    logic      cfg_wr;
    t_reg_idx  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[5:3]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_W'(256);
            r_stop_count  <= COUNT_W'(2);
            r_stop[0]     <= '0;
            r_stop[1]     <= STOP_W'(49'h1_0000_FFFF_FFFF);
            r_stop[2]     <= '0;
            r_stop[3]     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ENTRY_COUNT: r_entry_count <= pwdata[ENTRY_W-1:0];
                REG_STOP_COUNT:  r_stop_count  <= pwdata[COUNT_W-1:0];
                REG_STOP_ZERO:   r_stop[0]     <= pwdata[STOP_W-1:0];
                REG_STOP_ONE:    r_stop[1]     <= pwdata[STOP_W-1:0];
                REG_STOP_TWO:    r_stop[2]     <= pwdata[STOP_W-1:0];
                REG_STOP_THREE:  r_stop[3]     <= pwdata[STOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            REG_ENTRY_COUNT: prdata = PDATA_W'(r_entry_count);
            REG_STOP_COUNT:  prdata = PDATA_W'(r_stop_count);
            REG_STOP_ZERO:   prdata = PDATA_W'(r_stop[0]);
            REG_STOP_ONE:    prdata = PDATA_W'(r_stop[1]);
            REG_STOP_TWO:    prdata = PDATA_W'(r_stop[2]);
            REG_STOP_THREE:  prdata = PDATA_W'(r_stop[3]);
            default:         prdata = '0;
        endcase
    end

    // Configuration bundle for the front.
    always_comb begin
        cfg.entry_count = r_entry_count;
        cfg.stop_count  = r_stop_count;
        for (int i = 0; i < STOP_REGS; i++) begin
            cfg.stops[i] = r_stop[i];
        end
    end

    crg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_entry_index (i_entry_index),
        .o_full        (full),
        .i_queue_full  (queue_full),
        .o_job_valid   (front_valid),
        .o_job         (front_job)
    );

    crg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_rd    (queue_pop),
        .o_empty (queue_empty),
        .o_data  (back_job)
    );

    crg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (queue_empty),
        .i_job        (back_job),
        .o_job_pop    (queue_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_index_echo (o_index_echo),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha)
    );

endmodule
